/* design/fba_pkg.sv */
package fba_pkg;

	localparam int NUM_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_BITS   = $clog2(NUM_BLOCKS);
	localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

	// fixed field widths
	localparam int OP_BITS     = 2;
	localparam int POLICY_BITS = 2;
	localparam int BCOUNT_BITS = 5;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 5;

	typedef enum logic [OP_BITS-1:0] {
		OP_LOAD  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_ALLOC = 2'd2,
		OP_NONE  = 2'd3
	} fba_op_t;

	typedef enum logic [POLICY_BITS-1:0] {
		POL_FIRST = 2'd0,
		POL_BEST  = 2'd1,
		POL_NEXT  = 2'd2,
		POL_NONE  = 2'd3
	} fba_policy_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_POLICY = 1'b0,
		CFG_COUNT  = 1'b1
	} fba_cfg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clear;
		logic start;
		logic step;
		logic commit;
	} fba_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic scan_done;
	} fba_sts_t;

endpackage

/* design/fba_if.sv */
interface fba_req_if;
	logic                          valid;
	logic                          ready;
	logic [fba_pkg::OP_BITS-1:0]   opcode;
	logic [fba_pkg::IDX_BITS-1:0]  block_index;
	logic [fba_pkg::SIZE_BITS-1:0] block_size;
	logic [fba_pkg::SIZE_BITS-1:0] request_size;

	modport source (output valid, opcode, block_index, block_size, request_size, input ready);
	modport sink (input valid, opcode, block_index, block_size, request_size, output ready);
endinterface

interface fba_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          granted;
	logic [fba_pkg::IDX_BITS-1:0]  chosen_block;
	logic [fba_pkg::SIZE_BITS-1:0] leftover;

	modport source (output valid, granted, chosen_block, leftover, input ready);
	modport sink (input valid, granted, chosen_block, leftover, output ready);
endinterface

/* design/fit_block_allocator.sv */
// load and clear requests are taken only in idle and give no result
// an allocate request scans one table entry per cycle over the active count (at most 16),
// then writes the result register once it is free or its result is being taken;
// first fit and next fit stop at the first fitting entry, best fit always scans all
// one request is worked at a time; the result register frees the input side meanwhile
// reset sets first fit and a block count of 16, clears used marks and pointer; sizes need loading
module fit_block_allocator (
	input  logic                                clk,
	input  logic                                arst_n,
	fba_req_if.sink                             request,
	fba_rsp_if.source                           result,
	input  logic                                wr_en,
	input  logic [fba_pkg::CFG_IDX_BITS-1:0]    wr_index,
	input  logic [fba_pkg::CFG_DATA_BITS-1:0]   wr_data
);

	fba_pkg::fba_cmd_t cmd;
	fba_pkg::fba_sts_t sts;

	// sequencing of each request
	fba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.in_opcode (request.opcode),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// table, scan and result registers
	fba_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.in_block_index   (request.block_index),
		.in_block_size    (request.block_size),
		.in_request_size  (request.request_size),
		.cmd              (cmd),
		.sts              (sts),
		.out_granted      (result.granted),
		.out_chosen_block (result.chosen_block),
		.out_leftover     (result.leftover)
	);

endmodule

/* design/fba_ctrl.sv */
module fba_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fba_pkg::OP_BITS-1:0] in_opcode,
	output logic                        out_valid,
	input  logic                        out_ready,
	output fba_pkg::fba_cmd_t           cmd,
	input  fba_pkg::fba_sts_t           sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   can_commit;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign can_commit = !out_valid_q || out_ready;

	// commands to the datapath
	always_comb begin
		cmd.load   = accept && (in_opcode == fba_pkg::OP_LOAD);
		cmd.clear  = accept && (in_opcode == fba_pkg::OP_CLEAR);
		cmd.start  = accept && (in_opcode == fba_pkg::OP_ALLOC);
		cmd.step   = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_FINISH) && can_commit;
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= sts.empty ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (can_commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/fba_dpath.sv */
module fba_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [fba_pkg::CFG_IDX_BITS-1:0]    wr_index,
	input  logic [fba_pkg::CFG_DATA_BITS-1:0]   wr_data,
	input  logic [fba_pkg::IDX_BITS-1:0]        in_block_index,
	input  logic [fba_pkg::SIZE_BITS-1:0]       in_block_size,
	input  logic [fba_pkg::SIZE_BITS-1:0]       in_request_size,
	input  fba_pkg::fba_cmd_t                   cmd,
	output fba_pkg::fba_sts_t                   sts,
	output logic                                out_granted,
	output logic [fba_pkg::IDX_BITS-1:0]        out_chosen_block,
	output logic [fba_pkg::SIZE_BITS-1:0]       out_leftover
);

	// configuration
	fba_pkg::fba_policy_t                policy_q;
	logic [fba_pkg::BCOUNT_BITS-1:0]     bcount_q;

	// table state
	logic [fba_pkg::SIZE_BITS-1:0]       size_q [fba_pkg::NUM_BLOCKS];
	logic [fba_pkg::NUM_BLOCKS-1:0]      used_q;
	logic [fba_pkg::IDX_BITS-1:0]        next_start_q;

	// scan state
	fba_pkg::fba_policy_t                pol_q;
	logic [fba_pkg::SIZE_BITS-1:0]       req_q;
	logic [fba_pkg::CNT_BITS-1:0]        n_q;
	logic [fba_pkg::CNT_BITS-1:0]        count_q;
	logic [fba_pkg::IDX_BITS-1:0]        idx_q;
	logic                                found_q;
	logic [fba_pkg::IDX_BITS-1:0]        pick_q;
	logic [fba_pkg::SIZE_BITS-1:0]       best_q;

	logic [fba_pkg::CNT_BITS-1:0]        n_eff;
	logic [fba_pkg::IDX_BITS-1:0]        start_idx;
	logic [fba_pkg::SIZE_BITS-1:0]       cur_size;
	logic [fba_pkg::SIZE_BITS-1:0]       diff;
	logic                                fits;
	logic                                take;
	logic [fba_pkg::CNT_BITS-1:0]        idx_inc;

	// active block count, saturated to the table depth
	always_comb begin
		if (fba_pkg::CNT_BITS'(bcount_q) > fba_pkg::CNT_BITS'(fba_pkg::NUM_BLOCKS)) begin
			n_eff = fba_pkg::CNT_BITS'(fba_pkg::NUM_BLOCKS);
		end else begin
			n_eff = fba_pkg::CNT_BITS'(bcount_q);
		end
	end

	// next fit restarts at zero on a stale pointer
	always_comb begin
		start_idx = '0;
		if (policy_q == fba_pkg::POL_NEXT
				&& fba_pkg::CNT_BITS'(next_start_q) < n_eff) begin
			start_idx = next_start_q;
		end
	end

	assign sts.empty = (policy_q == fba_pkg::POL_NONE) || (n_eff == '0);

	// one table entry examined per cycle
	assign cur_size = size_q[idx_q];
	assign diff     = cur_size - req_q;
	assign fits     = !used_q[idx_q] && (cur_size >= req_q);
	assign idx_inc  = fba_pkg::CNT_BITS'(idx_q) + fba_pkg::CNT_BITS'(1);

	always_comb begin
		if (pol_q == fba_pkg::POL_BEST) begin
			take = fits && (!found_q || diff < best_q);
		end else begin
			take = fits && !found_q;
		end
	end

	assign sts.scan_done = (count_q == fba_pkg::CNT_BITS'(1))
		|| (pol_q != fba_pkg::POL_BEST && fits);

	// configuration registers, marks and pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q     <= fba_pkg::POL_FIRST;
			bcount_q     <= fba_pkg::BCOUNT_BITS'(16);
			used_q       <= '0;
			next_start_q <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					fba_pkg::CFG_POLICY: begin
						policy_q <= fba_pkg::fba_policy_t'(wr_data[fba_pkg::POLICY_BITS-1:0]);
					end
					fba_pkg::CFG_COUNT: begin
						bcount_q <= wr_data[fba_pkg::BCOUNT_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.clear) begin
				used_q       <= '0;
				next_start_q <= '0;
			end else if (cmd.commit && found_q) begin
				used_q[pick_q] <= 1'b1;
				if (pol_q == fba_pkg::POL_NEXT) begin
					next_start_q <= pick_q;
				end
			end
		end
	end

	// size table, written by load requests
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			size_q[in_block_index] <= in_block_size;
		end
	end

	// scan registers and result register
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pol_q   <= policy_q;
			req_q   <= in_request_size;
			n_q     <= n_eff;
			count_q <= n_eff;
			idx_q   <= start_idx;
			found_q <= 1'b0;
			pick_q  <= '0;
			best_q  <= '0;
		end else if (cmd.step) begin
			count_q <= count_q - fba_pkg::CNT_BITS'(1);
			if (idx_inc == n_q) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_inc[fba_pkg::IDX_BITS-1:0];
			end
			if (take) begin
				found_q <= 1'b1;
				pick_q  <= idx_q;
				best_q  <= diff;
			end
		end
		if (cmd.commit) begin
			out_granted      <= found_q;
			out_chosen_block <= found_q ? pick_q : '0;
			out_leftover     <= found_q ? best_q : '0;
		end
	end

endmodule
